// ----- sv/evs_pkg.sv -----
// Package for the event-set wait-queue engine.
// Holds sizes, operation and status codes, result and update structs, and the
// lowest-set-bit helper. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package evs_pkg;

    // number of event sets and the width of a set index
    localparam int NUM_SETS = 8;
    localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    localparam int EVT_W = 32;   // events per set, also threads per set
    localparam int IDX_W = 5;    // bits of an event or thread number

    typedef enum logic [1:0] {
        OP_WAIT   = 2'd0,
        OP_RAISE  = 2'd1,
        OP_MASK   = 2'd2,
        OP_UNMASK = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVAL   = 2'd1,
        ST_BLOCKED = 2'd2
    } t_status;

    // result of one item
    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] taken_event;
        logic             woke;
        logic [IDX_W-1:0] woken_thread;
        logic [IDX_W-1:0] woken_event;
    } t_result;

    // new words for the selected set
    typedef struct packed {
        logic             we;
        logic [EVT_W-1:0] en;
        logic [EVT_W-1:0] pend;
        logic [EVT_W-1:0] waitq;
    } t_update;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_lowest;

    // isolate the lowest set bit, then encode its position
    function automatic t_lowest lowest_bit(input logic [EVT_W-1:0] w);
        logic [EVT_W-1:0] onehot;
        t_lowest          r;
        onehot  = w & (~w + EVT_W'(1));
        r.found = |w;
        r.idx   = '0;
        for (int i = 0; i < EVT_W; i++) begin
            if (onehot[i]) begin
                r.idx = r.idx | IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/evs_exec.sv -----
// Operation logic of the event-set engine for one item on one set.
// Takes the selected set's words and returns the update and the result.
// Depends on evs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module evs_exec (
    input  var evs_pkg::t_op                 i_op,
    input  var logic                         i_set_ok,
    input  var logic [5:0]                   i_event_num,
    input  var logic [evs_pkg::IDX_W-1:0]    i_thread_id,
    input  var logic [evs_pkg::EVT_W-1:0]    i_en,
    input  var logic [evs_pkg::EVT_W-1:0]    i_pend,
    input  var logic [evs_pkg::EVT_W-1:0]    i_waitq,
    output evs_pkg::t_update                 o_upd,
    output evs_pkg::t_result                 o_res
);

    logic [evs_pkg::EVT_W-1:0] s_bit;
    logic [evs_pkg::EVT_W-1:0] s_thr_bit;
    evs_pkg::t_lowest          s_avail;
    evs_pkg::t_lowest          s_waiter;

    // event and thread bits, lowest ready event and lowest waiter
    always_comb begin
        s_bit     = evs_pkg::EVT_W'(1) << i_event_num[evs_pkg::IDX_W-1:0];
        s_thr_bit = evs_pkg::EVT_W'(1) << i_thread_id;
        s_avail   = evs_pkg::lowest_bit(i_pend & i_en);
        s_waiter  = evs_pkg::lowest_bit(i_waitq);
    end

    // operation decode
    always_comb begin
        o_upd.we    = 1'b0;
        o_upd.en    = i_en;
        o_upd.pend  = i_pend;
        o_upd.waitq = i_waitq;
        o_res       = '0;
        o_res.status = evs_pkg::ST_OK;

        if (!i_set_ok) begin
            o_res.status = evs_pkg::ST_INVAL;
        end else if (i_op != evs_pkg::OP_WAIT && i_event_num[5]) begin
            o_res.status = evs_pkg::ST_INVAL;
        end else begin
            o_upd.we = 1'b1;
            case (i_op)
                evs_pkg::OP_WAIT: begin
                    if (s_avail.found) begin
                        o_upd.pend = i_pend &
                            ~(evs_pkg::EVT_W'(1) << s_avail.idx);
                        o_res.taken_event = s_avail.idx;
                    end else begin
                        o_upd.waitq  = i_waitq | s_thr_bit;
                        o_res.status = evs_pkg::ST_BLOCKED;
                    end
                end
                evs_pkg::OP_RAISE: begin
                    // enabled event goes to a waiter when there is one
                    if ((i_en & s_bit) != '0 && s_waiter.found) begin
                        o_upd.waitq = i_waitq &
                            ~(evs_pkg::EVT_W'(1) << s_waiter.idx);
                        o_res.woke         = 1'b1;
                        o_res.woken_thread = s_waiter.idx;
                        o_res.woken_event  = i_event_num[evs_pkg::IDX_W-1:0];
                    end else begin
                        o_upd.pend = i_pend | s_bit;
                    end
                end
                evs_pkg::OP_MASK: begin
                    o_upd.en = i_en & ~s_bit;
                end
                evs_pkg::OP_UNMASK: begin
                    o_upd.en = i_en | s_bit;
                    // a pending event is handed to the lowest waiter
                    if ((i_pend & s_bit) != '0 && s_waiter.found) begin
                        o_upd.waitq = i_waitq &
                            ~(evs_pkg::EVT_W'(1) << s_waiter.idx);
                        o_upd.pend         = i_pend & ~s_bit;
                        o_res.woke         = 1'b1;
                        o_res.woken_thread = s_waiter.idx;
                        o_res.woken_event  = i_event_num[evs_pkg::IDX_W-1:0];
                    end
                end
                default: begin
                    o_upd.we = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/event_set_wait_queue_engine.sv -----
// Top level of the event-set wait-queue engine: input register, set state,
// result register. Depends on evs_pkg and evs_exec.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: operation,
//   object number, event number and thread number. Output channel
//   (o_out_valid / i_out_stall) returns exactly one result item per input.
//   i_cfg_we / i_cfg_data write object_base, the object number of set 0;
//   write it only while the engine is idle.
//   An accepted item is held in the input register; the set lookup, priority
//   encoders and the state write then happen on the edge that loads the
//   result register.
//   Throughput is one item per cycle unless the receiver stalls; the per-set
//   state is read and written in the same stage, so back-to-back items on
//   one set see each other. When the receiver stalls, the result register
//   holds, the input register fills, and o_in_stall is high while both are full.
//   Synchronous active-low reset: all enables set, pending bits and wait
//   bitmaps cleared, object_base zero, both registers empty. Items are
//   accepted as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module event_set_wait_queue_engine (
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    // configuration
    input  var logic       i_cfg_we,
    input  var logic [7:0] i_cfg_data,
    // input channel
    input  var logic       i_in_valid,
    output logic           o_in_stall,
    input  var logic [1:0] i_operation,
    input  var logic [7:0] i_object_id,
    input  var logic [5:0] i_event_num,
    input  var logic [4:0] i_thread_id,
    // output channel
    output logic           o_out_valid,
    input  var logic       i_out_stall,
    output logic [1:0]     o_status,
    output logic [4:0]     o_taken_event,
    output logic           o_woke,
    output logic [4:0]     o_woken_thread,
    output logic [4:0]     o_woken_event
);

    logic [7:0] r_obj_base;

    // input register
    logic                         r_in_valid;
    evs_pkg::t_op                 r_op;
    logic [7:0]                   r_obj;
    logic [5:0]                   r_ev;
    logic [evs_pkg::IDX_W-1:0]    r_th;

    // per-set state
    logic [evs_pkg::EVT_W-1:0] r_en    [evs_pkg::NUM_SETS];
    logic [evs_pkg::EVT_W-1:0] r_pend  [evs_pkg::NUM_SETS];
    logic [evs_pkg::EVT_W-1:0] r_waitq [evs_pkg::NUM_SETS];

    // result register
    logic              r_out_valid;
    evs_pkg::t_result  r_res;

    logic [7:0]                s_set_full;
    logic                      s_set_ok;
    logic [evs_pkg::SET_W-1:0] s_set;
    logic                      s_out_free;
    logic                      s_adv;
    evs_pkg::t_update          s_upd;
    evs_pkg::t_result          s_res;

    // handshake
    assign s_out_free = !r_out_valid || !i_out_stall;
    assign s_adv      = r_in_valid && s_out_free;
    assign o_in_stall = r_in_valid && !s_out_free;

    // set index from object number
    assign s_set_full = r_obj - r_obj_base;
    assign s_set_ok   = s_set_full < 8'(evs_pkg::NUM_SETS);
    assign s_set      = s_set_full[evs_pkg::SET_W-1:0];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_base <= '0;
        end else if (i_cfg_we) begin
            r_obj_base <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op  <= evs_pkg::t_op'(i_operation);
            r_obj <= i_object_id;
            r_ev  <= i_event_num;
            r_th  <= i_thread_id;
        end
    end

    evs_exec u_exec (
        .i_op        (r_op),
        .i_set_ok    (s_set_ok),
        .i_event_num (r_ev),
        .i_thread_id (r_th),
        .i_en        (r_en[s_set]),
        .i_pend      (r_pend[s_set]),
        .i_waitq     (r_waitq[s_set]),
        .o_upd       (s_upd),
        .o_res       (s_res)
    );

    // set state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < evs_pkg::NUM_SETS; i++) begin
                r_en[i]    <= '1;
                r_pend[i]  <= '0;
                r_waitq[i] <= '0;
            end
        end else if (s_adv && s_upd.we) begin
            r_en[s_set]    <= s_upd.en;
            r_pend[s_set]  <= s_upd.pend;
            r_waitq[s_set] <= s_upd.waitq;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_res <= s_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_res.status;
    assign o_taken_event  = r_res.taken_event;
    assign o_woke         = r_res.woke;
    assign o_woken_thread = r_res.woken_thread;
    assign o_woken_event  = r_res.woken_event;

    // a released thread was waiting on the selected set
    a_woke_was_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && s_res.woke |-> r_waitq[s_set][s_res.woken_thread])
        else $error("woken thread was not waiting");

    // a blocked wait leaves the caller in the wait bitmap
    a_blocked_enqueued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && s_res.status == evs_pkg::ST_BLOCKED |=> r_waitq[$past(s_set)][$past(r_th)])
        else $error("blocked thread missing from wait bitmap");

    // an invalid item never changes set state
    a_inval_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res.status == evs_pkg::ST_INVAL |-> !s_upd.we)
        else $error("state written on invalid item");

    // a wake always comes with an ok status
    a_woke_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_woke |-> o_status == evs_pkg::ST_OK)
        else $error("wake reported with bad status");

endmodule

`default_nettype wire
